// ===== hw/rtl/vcrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vcrp_pkg
// shared types and constants of the video chip register port
// ----------------------------------------------------------------------------
package vcrp_pkg;

   localparam int SPRITE_BYTES    = 256;
   localparam int SPRITE_AW       = $clog2(SPRITE_BYTES);
   localparam int PALETTE_ENTRIES = 32;
   localparam int PALETTE_AW      = $clog2(PALETTE_ENTRIES);

   localparam logic [2:0] KIND_READ     = 3'd0;
   localparam logic [2:0] KIND_PEEK     = 3'd1;
   localparam logic [2:0] KIND_WRITE    = 3'd2;
   localparam logic [2:0] KIND_VBLANK   = 3'd3;
   localparam logic [2:0] KIND_PRERENDR = 3'd4;
   localparam logic [2:0] KIND_SPR_REP  = 3'd5;

   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_SPR_ADDR = 3'd3;
   localparam logic [2:0] REG_SPR_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   localparam logic [5:0]  PALETTE_PAGE = 6'h3F;
   localparam logic [15:0] FILL_OFFSET  = 16'h1000;
   localparam logic [7:0]  GREY_MASK    = 8'h30;
   localparam logic [15:0] STEP_WIDE    = 16'd32;
   localparam logic [15:0] STEP_NARROW  = 16'd1;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] reg_index;
      logic [7:0] write_data;
      logic [7:0] vram_byte;
      logic       in_render_window;
      logic       report_sprite0_hit;
      logic       report_overflow;
   } item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        nmi_level;
      logic        mem_write;
      logic        mem_read;
      logic [15:0] mem_addr;
      logic [7:0]  mem_data;
      logic [15:0] cur_vram_addr;
      logic [14:0] tmp_vram_addr;
      logic [2:0]  fine_x;
      logic [7:0]  ctrl_bits;
      logic [7:0]  mask_bits;
   } result_type;

endpackage

// ===== hw/rtl/vcrp_ram.sv =====
// ----------------------------------------------------------------------------
// vcrp_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module vcrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

// ===== hw/rtl/vcrp_core.sv =====
// ----------------------------------------------------------------------------
// vcrp_core
// register state, sprite memory, palette and per-word update logic
// ----------------------------------------------------------------------------
module vcrp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  vcrp_pkg::item_type   item,
   output vcrp_pkg::result_type result
);

   logic [7:0]  open_bus_ff, open_bus_in;
   logic [7:0]  read_buffer_ff, read_buffer_in;
   logic        toggle_ff, toggle_in;
   logic [15:0] cur_ff, cur_in;
   logic [14:0] tmp_ff, tmp_in;
   logic [2:0]  fine_ff, fine_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic        irq_ff, irq_in;
   logic [vcrp_pkg::SPRITE_AW-1:0] ptr_ff, ptr_in;
   logic [vcrp_pkg::SPRITE_BYTES-1:0] spr_valid_ff;
   logic [7:0]  pal_ff [vcrp_pkg::PALETTE_ENTRIES];

   logic [7:0]  spr_q;
   logic        spr_we;
   logic        pal_we;
   logic [vcrp_pkg::PALETTE_AW-1:0] pal_idx;
   logic        pal_range;
   logic        peek;
   logic [15:0] cur_step;
   logic [7:0]  status_byte;
   logic [7:0]  spr_byte;
   logic [7:0]  pal_byte;
   logic [7:0]  data_byte;
   logic [15:0] fill_addr;
   logic [7:0]  rd;
   logic        mwrite;
   logic        mread;
   logic [15:0] maddr;
   logic [7:0]  mdata;
   logic [7:0]  val;

   vcrp_ram #(
      .WIDTH (8),
      .DEPTH (vcrp_pkg::SPRITE_BYTES)
   ) u_sprite_ram (
      .clock      (clock),
      .wr_en      (spr_we),
      .wr_addr    (ptr_ff),
      .wr_data    (item.write_data),
      .rd_addr    (ptr_in),
      .rd_data_ff (spr_q)
   );

   // palette mirrors 0x10/0x14/0x18/0x1c onto the background entries
   always_comb begin
      pal_idx = cur_ff[vcrp_pkg::PALETTE_AW-1:0];
      if (pal_idx[4] && (pal_idx[1:0] == 2'b00)) begin
         pal_idx[4] = 1'b0;
      end
   end

   assign pal_range   = (cur_ff[13:8] == vcrp_pkg::PALETTE_PAGE);
   assign peek        = (item.kind == vcrp_pkg::KIND_PEEK);
   assign cur_step    = cur_ff + (ctrl_ff[2] ? vcrp_pkg::STEP_WIDE : vcrp_pkg::STEP_NARROW);
   assign status_byte = {status_ff, open_bus_ff[4:0]};
   assign spr_byte    = spr_valid_ff[ptr_ff] ? spr_q : 8'h00;
   assign pal_byte    = mask_ff[0] ? (pal_ff[pal_idx] & vcrp_pkg::GREY_MASK) : pal_ff[pal_idx];
   assign data_byte   = pal_range ? pal_byte : read_buffer_ff;
   assign fill_addr   = pal_range ? (cur_ff - vcrp_pkg::FILL_OFFSET) : cur_ff;
   assign val         = item.write_data;

   always_comb begin
      open_bus_in    = open_bus_ff;
      read_buffer_in = read_buffer_ff;
      toggle_in      = toggle_ff;
      cur_in         = cur_ff;
      tmp_in         = tmp_ff;
      fine_in        = fine_ff;
      ctrl_in        = ctrl_ff;
      mask_in        = mask_ff;
      status_in      = status_ff;
      irq_in         = irq_ff;
      ptr_in         = ptr_ff;
      spr_we         = 1'b0;
      pal_we         = 1'b0;
      rd             = open_bus_ff;
      mwrite         = 1'b0;
      mread          = 1'b0;
      maddr          = 16'h0000;
      mdata          = 8'h00;
      if (fire) begin
         case (item.kind)
            vcrp_pkg::KIND_READ, vcrp_pkg::KIND_PEEK: begin
               case (item.reg_index)
                  vcrp_pkg::REG_STATUS: begin
                     rd = status_byte;
                     if (!peek) begin
                        open_bus_in = status_byte;
                        status_in   = {1'b0, status_ff[1:0]};
                        irq_in      = 1'b0;
                        toggle_in   = 1'b0;
                     end
                  end
                  vcrp_pkg::REG_SPR_DATA: begin
                     rd = spr_byte;
                     if (!peek) begin
                        open_bus_in = spr_byte;
                     end
                  end
                  vcrp_pkg::REG_DATA: begin
                     rd = data_byte;
                     if (!peek) begin
                        read_buffer_in = item.vram_byte;
                        mread          = 1'b1;
                        maddr          = fill_addr;
                        cur_in         = cur_step;
                        open_bus_in    = data_byte;
                     end
                  end
                  default: begin
                     rd = open_bus_ff;
                  end
               endcase
            end
            vcrp_pkg::KIND_WRITE: begin
               open_bus_in = val;
               rd          = val;
               case (item.reg_index)
                  vcrp_pkg::REG_CTRL: begin
                     ctrl_in        = val;
                     irq_in         = val[7] & status_ff[2];
                     tmp_in[11:10]  = val[1:0];
                  end
                  vcrp_pkg::REG_MASK: begin
                     mask_in = val;
                  end
                  vcrp_pkg::REG_SPR_ADDR: begin
                     ptr_in = val;
                  end
                  vcrp_pkg::REG_SPR_DATA: begin
                     if (!((mask_ff[4] | mask_ff[3]) && item.in_render_window)) begin
                        spr_we = 1'b1;
                        ptr_in = ptr_ff + vcrp_pkg::SPRITE_AW'(1);
                     end
                  end
                  vcrp_pkg::REG_SCROLL: begin
                     if (!toggle_ff) begin
                        tmp_in[4:0] = val[7:3];
                        fine_in     = val[2:0];
                        toggle_in   = 1'b1;
                     end else begin
                        tmp_in[9:5]   = val[7:3];
                        tmp_in[14:12] = val[2:0];
                        toggle_in     = 1'b0;
                     end
                  end
                  vcrp_pkg::REG_ADDR: begin
                     if (!toggle_ff) begin
                        tmp_in[14]   = 1'b0;
                        tmp_in[13:8] = val[5:0];
                        toggle_in    = 1'b1;
                     end else begin
                        tmp_in[7:0] = val;
                        toggle_in   = 1'b0;
                        cur_in      = {1'b0, tmp_ff[14:8], val};
                     end
                  end
                  vcrp_pkg::REG_DATA: begin
                     if (pal_range) begin
                        pal_we = 1'b1;
                     end else begin
                        mwrite = 1'b1;
                        maddr  = cur_ff;
                        mdata  = val;
                     end
                     cur_in = cur_step;
                  end
                  default: begin
                     open_bus_in = val;
                  end
               endcase
            end
            vcrp_pkg::KIND_VBLANK: begin
               status_in[2] = 1'b1;
               if (ctrl_ff[7]) begin
                  irq_in = 1'b1;
               end
            end
            vcrp_pkg::KIND_PRERENDR: begin
               status_in = 3'b000;
               irq_in    = 1'b0;
            end
            vcrp_pkg::KIND_SPR_REP: begin
               status_in[1] = status_ff[1] | item.report_sprite0_hit;
               status_in[0] = status_ff[0] | item.report_overflow;
            end
            default: begin
               rd = open_bus_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_bus_ff    <= '0;
         read_buffer_ff <= '0;
         toggle_ff      <= 1'b0;
         cur_ff         <= '0;
         tmp_ff         <= '0;
         fine_ff        <= '0;
         ctrl_ff        <= '0;
         mask_ff        <= '0;
         status_ff      <= '0;
         irq_ff         <= 1'b0;
         ptr_ff         <= '0;
         spr_valid_ff   <= '0;
         for (int i = 0; i < vcrp_pkg::PALETTE_ENTRIES; i++) begin
            pal_ff[i] <= '0;
         end
      end else begin
         open_bus_ff    <= open_bus_in;
         read_buffer_ff <= read_buffer_in;
         toggle_ff      <= toggle_in;
         cur_ff         <= cur_in;
         tmp_ff         <= tmp_in;
         fine_ff        <= fine_in;
         ctrl_ff        <= ctrl_in;
         mask_ff        <= mask_in;
         status_ff      <= status_in;
         irq_ff         <= irq_in;
         ptr_ff         <= ptr_in;
         if (spr_we) begin
            spr_valid_ff[ptr_ff] <= 1'b1;
         end
         if (pal_we) begin
            pal_ff[pal_idx] <= val;
         end
      end
   end

   always_comb begin
      result.read_data     = rd;
      result.nmi_level     = irq_in;
      result.mem_write     = mwrite;
      result.mem_read      = mread;
      result.mem_addr      = maddr;
      result.mem_data      = mdata;
      result.cur_vram_addr = cur_in;
      result.tmp_vram_addr = tmp_in;
      result.fine_x        = fine_in;
      result.ctrl_bits     = ctrl_in;
      result.mask_bits     = mask_in;
   end

   // interrupt only while vblank flag is up
   a_irq_needs_vblank: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> status_ff[2])
      else $error("interrupt line high without vblank flag");

   // sprite port write moves the pointer by one
   a_spr_ptr_step: assert property (@(posedge clock) disable iff (reset)
      spr_we |=> (ptr_ff == $past(ptr_ff) + vcrp_pkg::SPRITE_AW'(1)))
      else $error("sprite pointer did not step after write");

   // state only moves on an accepted word
   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |=> ($stable(cur_ff) && $stable(tmp_ff) && $stable(status_ff)))
      else $error("register state changed without a word");

   // never both an external read and write for one word
   a_mem_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mwrite && mread))
      else $error("memory read and write in one word");

endmodule

// ===== hw/rtl/video_chip_register_port_top.sv =====
// ----------------------------------------------------------------------------
// video_chip_register_port_top
// processor register port of a tile video chip
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one word: a processor read, peek or write of one of the
//   eight registers, or a renderer event (vblank start, prerender clear,
//   sprite flag report). req_vram_byte is the external byte at the refill
//   address that the same word reports on rsp_mem_addr for a data port read.
//   rsp_* returns exactly one word per request: read data, interrupt level,
//   the external memory access to perform, and the scroll/address state.
//   path: an accepted word goes from the input register through the update
//   logic into the result register, where rsp_valid rises.
//   throughput: one word per cycle while rsp_stall is low; the input register
//   refills while a finished word waits in the result register.
//   rsp_stall holds the result word; the input register then holds one more
//   word and req_stall rises until the result is taken.
//   reset clears valid flags and core registers; palette and sprite memory
//   read as zero until written; the port accepts a word right after reset.
// ----------------------------------------------------------------------------
module video_chip_register_port_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_vram_byte,
   input  logic        req_in_render_window,
   input  logic        req_report_sprite0_hit,
   input  logic        req_report_overflow,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_nmi_level,
   output logic        rsp_mem_write,
   output logic        rsp_mem_read,
   output logic [15:0] rsp_mem_addr,
   output logic [7:0]  rsp_mem_data,
   output logic [15:0] rsp_cur_vram_addr,
   output logic [14:0] rsp_tmp_vram_addr,
   output logic [2:0]  rsp_fine_x,
   output logic [7:0]  rsp_ctrl_bits,
   output logic [7:0]  rsp_mask_bits
);

   logic                 s1_valid_ff, s1_valid_in;
   vcrp_pkg::item_type   s1_item_ff;
   logic                 out_valid_ff, out_valid_in;
   vcrp_pkg::result_type out_ff;
   vcrp_pkg::result_type core_result;
   logic                 fire;
   logic                 req_accept;

   assign fire       = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & ~fire;
   assign req_accept = req_valid & ~req_stall;

   assign s1_valid_in  = req_accept | (s1_valid_ff & ~fire);
   assign out_valid_in = fire | (out_valid_ff & rsp_stall);

   vcrp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (s1_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_accept) begin
         s1_item_ff.kind               <= req_kind;
         s1_item_ff.reg_index          <= req_reg_index;
         s1_item_ff.write_data         <= req_write_data;
         s1_item_ff.vram_byte          <= req_vram_byte;
         s1_item_ff.in_render_window   <= req_in_render_window;
         s1_item_ff.report_sprite0_hit <= req_report_sprite0_hit;
         s1_item_ff.report_overflow    <= req_report_overflow;
      end
      if (fire) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_ff.read_data;
   assign rsp_nmi_level     = out_ff.nmi_level;
   assign rsp_mem_write     = out_ff.mem_write;
   assign rsp_mem_read      = out_ff.mem_read;
   assign rsp_mem_addr      = out_ff.mem_addr;
   assign rsp_mem_data      = out_ff.mem_data;
   assign rsp_cur_vram_addr = out_ff.cur_vram_addr;
   assign rsp_tmp_vram_addr = out_ff.tmp_vram_addr;
   assign rsp_fine_x        = out_ff.fine_x;
   assign rsp_ctrl_bits     = out_ff.ctrl_bits;
   assign rsp_mask_bits     = out_ff.mask_bits;

   a_fire_fills_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed word did not reach the result register");

   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled without a blocked word");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |-> !fire)
      else $error("result register overwritten while stalled");

endmodule

// ===== dv/video_chip_register_port_top_tb.sv =====
// ----------------------------------------------------------------------------
// video_chip_register_port_top_tb
// ----------------------------------------------------------------------------
// Self-checking bench for the processor register port of the tile video chip.
// A short table of hand-picked words covers reset values, every register,
// status read side effects, sprite memory wrap and blocked writes, palette
// mirroring with greyscale, the wide address step, data port peeks and the
// unused kinds. Random register traffic follows. It mixes well-formed address
// write pairs followed by data port accesses, scroll write pairs, sprite
// memory accesses, single register words, renderer events and stray words.
// Every word accepted on the request side runs through a behavioral model
// of the port. Each response is compared field by field, in order, against
// the model. Both sides idle in random bursts. The response side also holds
// off once for a long stretch, and the request side drains once.
// ----------------------------------------------------------------------------
module video_chip_register_port_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vcrp_pkg::*;

   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam int RANDOM_WORDS = 750;
   localparam int CALM_WORDS   = 80;
   localparam int HOLD_AT      = 300;
   localparam int LONG_HOLD    = 120;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct packed {
      item_type   word;
      logic       fixed;
      logic [7:0] fixed_read;
   } opening_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = '0;
   logic [2:0]  req_reg_index = '0;
   logic [7:0]  req_write_data = '0;
   logic [7:0]  req_vram_byte = '0;
   logic        req_in_render_window = 1'b0;
   logic        req_report_sprite0_hit = 1'b0;
   logic        req_report_overflow = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_nmi_level;
   logic        rsp_mem_write;
   logic        rsp_mem_read;
   logic [15:0] rsp_mem_addr;
   logic [7:0]  rsp_mem_data;
   logic [15:0] rsp_cur_vram_addr;
   logic [14:0] rsp_tmp_vram_addr;
   logic [2:0]  rsp_fine_x;
   logic [7:0]  rsp_ctrl_bits;
   logic [7:0]  rsp_mask_bits;

   // model state
   logic [7:0]  latch_byte;
   logic [7:0]  buffered_byte;
   logic        second_half;
   logic [15:0] vram_addr;
   logic [14:0] scroll_addr;
   logic [2:0]  fine_scroll_x;
   logic [7:0]  ctrl_reg;
   logic [7:0]  mask_reg;
   logic [2:0]  flag_bits;
   logic        nmi_line;
   logic [7:0]  oam_ptr;
   logic [7:0]  oam_bytes [SPRITE_BYTES];
   logic [7:0]  palette_bytes [PALETTE_ENTRIES];

   result_type awaited_responses [$];
   item_type   word_plan [$];
   int         words_taken = 0;
   int         responses_checked = 0;
   int         mismatches = 0;
   int         cycle_count = 0;
   int         feed_idle_pct = 0;
   int         drain_idle_pct = 0;
   bit         calm = 1'b0;
   bit         long_hold_done = 1'b0;

   opening_row_type opening_rows [25] = '{
      '{'{KIND_READ,     REG_STATUS,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h00},
      '{'{KIND_READ,     REG_DATA,     8'h00, 8'hFF, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h00},
      '{'{KIND_PEEK,     REG_DATA,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_VBLANK,   REG_DATA,     8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_CTRL,     8'h84, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h84},
      '{'{KIND_PEEK,     REG_STATUS,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_READ,     REG_STATUS,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_SPR_REP,  REG_CTRL,     8'h00, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_MASK,     8'h19, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h19},
      '{'{KIND_WRITE,    REG_SPR_ADDR, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_SPR_DATA, 8'hA5, 8'h00, 1'b1, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_SPR_DATA, 8'h5A, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_READ,     REG_SPR_DATA, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_ADDR,     8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_ADDR,     8'h10, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_DATA,     8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_ADDR,     8'h3F, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_ADDR,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_READ,     REG_DATA,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b1, 8'h30},
      '{'{KIND_WRITE,    REG_SCROLL,   8'hFF, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_WRITE,    REG_SCROLL,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_READ,     REG_CTRL,     8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00},
      '{'{KIND_SPARE6,   REG_DATA,     8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, 8'h00},
      '{'{KIND_SPARE7,   REG_DATA,     8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, 8'h00},
      '{'{KIND_PRERENDR, REG_STATUS,   8'h00, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, 8'h00}
   };

   video_chip_register_port_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_kind               (req_kind),
      .req_reg_index          (req_reg_index),
      .req_write_data         (req_write_data),
      .req_vram_byte          (req_vram_byte),
      .req_in_render_window   (req_in_render_window),
      .req_report_sprite0_hit (req_report_sprite0_hit),
      .req_report_overflow    (req_report_overflow),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_read_data          (rsp_read_data),
      .rsp_nmi_level          (rsp_nmi_level),
      .rsp_mem_write          (rsp_mem_write),
      .rsp_mem_read           (rsp_mem_read),
      .rsp_mem_addr           (rsp_mem_addr),
      .rsp_mem_data           (rsp_mem_data),
      .rsp_cur_vram_addr      (rsp_cur_vram_addr),
      .rsp_tmp_vram_addr      (rsp_tmp_vram_addr),
      .rsp_fine_x             (rsp_fine_x),
      .rsp_ctrl_bits          (rsp_ctrl_bits),
      .rsp_mask_bits          (rsp_mask_bits)
   );

   always #10 clock = ~clock;

   function automatic logic [4:0] palette_slot(input logic [15:0] addr);
      logic [4:0] slot;
      slot = addr[4:0];
      if (slot[4] && slot[1:0] == 2'b00) begin
         slot[4] = 1'b0;
      end
      return slot;
   endfunction

   function automatic result_type emulate_register_port(input item_type w);
      result_type r;
      logic [7:0]  d;
      logic [15:0] fill;
      logic        in_palette;
      logic        reading;
      r = '0;
      in_palette = (vram_addr[13:8] == PALETTE_PAGE);
      reading = (w.kind == KIND_READ);
      r.read_data = latch_byte;
      if (w.kind == KIND_READ || w.kind == KIND_PEEK) begin
         case (w.reg_index)
            REG_STATUS: begin
               d = {flag_bits, latch_byte[4:0]};
               r.read_data = d;
               if (reading) begin
                  latch_byte = d;
                  flag_bits[2] = 1'b0;
                  nmi_line = 1'b0;
                  second_half = 1'b0;
               end
            end
            REG_SPR_DATA: begin
               r.read_data = oam_bytes[oam_ptr];
               if (reading) begin
                  latch_byte = oam_bytes[oam_ptr];
               end
            end
            REG_DATA: begin
               if (in_palette) begin
                  d = palette_bytes[palette_slot(vram_addr)];
                  if (mask_reg[0]) begin
                     d &= GREY_MASK;
                  end
                  fill = vram_addr - FILL_OFFSET;
               end else begin
                  d = buffered_byte;
                  fill = vram_addr;
               end
               r.read_data = d;
               if (reading) begin
                  buffered_byte = w.vram_byte;
                  r.mem_read = 1'b1;
                  r.mem_addr = fill;
                  vram_addr = vram_addr + (ctrl_reg[2] ? STEP_WIDE : STEP_NARROW);
                  latch_byte = d;
               end
            end
            default: ;
         endcase
      end else if (w.kind == KIND_WRITE) begin
         latch_byte = w.write_data;
         r.read_data = w.write_data;
         case (w.reg_index)
            REG_CTRL: begin
               ctrl_reg = w.write_data;
               nmi_line = w.write_data[7] & flag_bits[2];
               scroll_addr[11:10] = w.write_data[1:0];
            end
            REG_MASK: mask_reg = w.write_data;
            REG_SPR_ADDR: oam_ptr = w.write_data;
            REG_SPR_DATA: begin
               if (!((mask_reg[3] || mask_reg[4]) && w.in_render_window)) begin
                  oam_bytes[oam_ptr] = w.write_data;
                  oam_ptr = oam_ptr + 8'd1;
               end
            end
            REG_SCROLL: begin
               if (!second_half) begin
                  scroll_addr[4:0] = w.write_data[7:3];
                  fine_scroll_x = w.write_data[2:0];
                  second_half = 1'b1;
               end else begin
                  scroll_addr[9:5] = w.write_data[7:3];
                  scroll_addr[14:12] = w.write_data[2:0];
                  second_half = 1'b0;
               end
            end
            REG_ADDR: begin
               if (!second_half) begin
                  scroll_addr[14:8] = {1'b0, w.write_data[5:0]};
                  second_half = 1'b1;
               end else begin
                  scroll_addr[7:0] = w.write_data;
                  second_half = 1'b0;
                  vram_addr = {1'b0, scroll_addr};
               end
            end
            REG_DATA: begin
               if (in_palette) begin
                  palette_bytes[palette_slot(vram_addr)] = w.write_data;
               end else begin
                  r.mem_write = 1'b1;
                  r.mem_addr = vram_addr;
                  r.mem_data = w.write_data;
               end
               vram_addr = vram_addr + (ctrl_reg[2] ? STEP_WIDE : STEP_NARROW);
            end
            default: ;
         endcase
      end else if (w.kind == KIND_VBLANK) begin
         flag_bits[2] = 1'b1;
         if (ctrl_reg[7]) begin
            nmi_line = 1'b1;
         end
      end else if (w.kind == KIND_PRERENDR) begin
         flag_bits = 3'b000;
         nmi_line = 1'b0;
      end else if (w.kind == KIND_SPR_REP) begin
         flag_bits[1] = flag_bits[1] | w.report_sprite0_hit;
         flag_bits[0] = flag_bits[0] | w.report_overflow;
      end
      r.nmi_level = nmi_line;
      r.cur_vram_addr = vram_addr;
      r.tmp_vram_addr = scroll_addr;
      r.fine_x = fine_scroll_x;
      r.ctrl_bits = ctrl_reg;
      r.mask_bits = mask_reg;
      return r;
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 6;
         default: return 20;
      endcase
   endfunction

   task automatic add_word(input logic [2:0] kind, input logic [2:0] ri, input logic [7:0] wd);
      item_type w;
      w.kind = kind;
      w.reg_index = ri;
      w.write_data = wd;
      w.vram_byte = any_byte();
      w.in_render_window = 1'($urandom_range(0, 1));
      w.report_sprite0_hit = 1'($urandom_range(0, 1));
      w.report_overflow = 1'($urandom_range(0, 1));
      word_plan.push_back(w);
   endtask

   task automatic plan_sequence();
      int         pick;
      int         n;
      logic [7:0] hi;
      logic [2:0] k;
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
         if ($urandom_range(0, 1) == 1) add_word(KIND_READ, REG_STATUS, any_byte());
         hi = any_byte();
         if ($urandom_range(0, 2) == 0) hi[5:0] = PALETTE_PAGE;
         add_word(KIND_WRITE, REG_ADDR, hi);
         add_word(KIND_WRITE, REG_ADDR, any_byte());
         n = $urandom_range(1, 6);
         repeat (n) begin
            k = ($urandom_range(0, 2) == 0) ? KIND_WRITE : KIND_READ;
            if ($urandom_range(0, 5) == 0) k = KIND_PEEK;
            add_word(k, REG_DATA, any_byte());
         end
      end else if (pick < 30) begin
         if ($urandom_range(0, 1) == 1) add_word(KIND_READ, REG_STATUS, any_byte());
         add_word(KIND_WRITE, REG_SCROLL, any_byte());
         add_word(KIND_WRITE, REG_SCROLL, any_byte());
      end else if (pick < 38) begin
         add_word(KIND_WRITE, REG_SPR_ADDR, any_byte());
         n = $urandom_range(1, 5);
         repeat (n) begin
            k = ($urandom_range(0, 2) == 0) ? KIND_READ : KIND_WRITE;
            add_word(k, REG_SPR_DATA, any_byte());
         end
      end else if (pick < 56) begin
         add_word(KIND_WRITE, 3'($urandom_range(0, 7)), any_byte());
      end else if (pick < 74) begin
         k = ($urandom_range(0, 3) == 0) ? KIND_PEEK : KIND_READ;
         add_word(k, 3'($urandom_range(0, 7)), any_byte());
      end else if (pick < 95) begin
         k = 3'($urandom_range(KIND_VBLANK, KIND_SPR_REP));
         add_word(k, 3'($urandom_range(0, 7)), any_byte());
      end else begin
         k = ($urandom_range(0, 1) == 0) ? KIND_SPARE6 : KIND_SPARE7;
         add_word(k, 3'($urandom_range(0, 7)), any_byte());
      end
   endtask

   task automatic offer_word(input item_type w, input logic fixed, input logic [7:0] fixed_read);
      result_type want;
      if (!calm && $urandom_range(0, 99) < feed_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_kind <= w.kind;
      req_reg_index <= w.reg_index;
      req_write_data <= w.write_data;
      req_vram_byte <= w.vram_byte;
      req_in_render_window <= w.in_render_window;
      req_report_sprite0_hit <= w.report_sprite0_hit;
      req_report_overflow <= w.report_overflow;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = emulate_register_port(w);
      if (fixed) want.read_data = fixed_read;
      awaited_responses.push_back(want);
      words_taken++;
      @(negedge clock);
   endtask

   task automatic check_field(input string label, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("response %0d: %s expected %h got %h", responses_checked, label, want, got);
         end
      end
   endtask

   initial begin
      latch_byte = '0;
      buffered_byte = '0;
      second_half = 1'b0;
      vram_addr = '0;
      scroll_addr = '0;
      fine_scroll_x = '0;
      ctrl_reg = '0;
      mask_reg = '0;
      flag_bits = '0;
      nmi_line = 1'b0;
      oam_ptr = '0;
      foreach (oam_bytes[i]) oam_bytes[i] = '0;
      foreach (palette_bytes[i]) palette_bytes[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (opening_rows[i]) begin
         offer_word(opening_rows[i].word, opening_rows[i].fixed, opening_rows[i].fixed_read);
      end
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            do @(negedge clock); while (awaited_responses.size() != 0);
         end
         if (i % 40 == 0) feed_idle_pct = pick_rate();
         calm = (i >= RANDOM_WORDS - CALM_WORDS);
         if (word_plan.size() == 0) plan_sequence();
         offer_word(word_plan.pop_front(), 1'b0, 8'h00);
      end
      req_valid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // response side back-pressure
   initial begin
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!long_hold_done && words_taken >= HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 99) < drain_idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 49) == 0) drain_idle_pct = pick_rate();
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("response %0d: arrived with nothing outstanding", responses_checked);
            end
         end else begin
            want = awaited_responses.pop_front();
            check_field("read_data", 16'(rsp_read_data), 16'(want.read_data));
            check_field("nmi_level", 16'(rsp_nmi_level), 16'(want.nmi_level));
            check_field("mem_write", 16'(rsp_mem_write), 16'(want.mem_write));
            check_field("mem_read", 16'(rsp_mem_read), 16'(want.mem_read));
            check_field("mem_addr", rsp_mem_addr, want.mem_addr);
            check_field("mem_data", 16'(rsp_mem_data), 16'(want.mem_data));
            check_field("cur_vram_addr", rsp_cur_vram_addr, want.cur_vram_addr);
            check_field("tmp_vram_addr", 16'(rsp_tmp_vram_addr), 16'(want.tmp_vram_addr));
            check_field("fine_x", 16'(rsp_fine_x), 16'(want.fine_x));
            check_field("ctrl_bits", 16'(rsp_ctrl_bits), 16'(want.ctrl_bits));
            check_field("mask_bits", 16'(rsp_mask_bits), 16'(want.mask_bits));
         end
         responses_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

// ===== files.f =====
hw/rtl/vcrp_pkg.sv
hw/rtl/vcrp_ram.sv
hw/rtl/vcrp_core.sv
hw/rtl/video_chip_register_port_top.sv
dv/video_chip_register_port_top_tb.sv
